// ===== hw/rtl/bvns_pkg.sv =====
package bvns_pkg;

  localparam int GRID_SIDE  = 16;
  localparam int VALUE_BITS = 16;
  localparam int IDX_W      = $clog2(GRID_SIDE);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int CORNERS    = 4;
  localparam int PADDR_W    = 3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_WRAP  = 1'b1;

  localparam logic [3:0] SCALE_RESET = 4'd2;

  // (f + 1) / 2 in Q0.16, f the fraction of |c| carrying the sign of c
  function automatic logic [15:0] unit_coord(input logic [31:0] c);
    logic        neg;
    logic [15:0] frac;
    logic [16:0] sum;
    neg  = c[31];
    frac = neg ? (16'd0 - c[15:0]) : c[15:0];
    sum  = neg ? (17'h10000 - {1'b0, frac}) : (17'h10000 + {1'b0, frac});
    return sum[16:1];
  endfunction

  // (a*(1-w) + b*w) >> 16 written as a + floor((b-a)*w / 2^16)
  function automatic logic [VALUE_BITS-1:0] lerp(input logic [VALUE_BITS-1:0] a,
                                                 input logic [VALUE_BITS-1:0] b,
                                                 input logic [15:0]           w);
    logic signed [VALUE_BITS:0]    d;
    logic signed [VALUE_BITS+17:0] prod;
    logic signed [VALUE_BITS+17:0] sh;
    d    = signed'({1'b0, b}) - signed'({1'b0, a});
    prod = d * signed'({1'b0, w});
    sh   = prod >>> 16;
    return a + sh[VALUE_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/bvns_ram.sv =====
module bvns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/bilinear_value_noise_sampler_top.sv =====
// Bilinear value-noise sampler.
// Input channel (in_valid / in_stall): opcode 0 writes grid_value into the
// lattice at (grid_col, grid_row) and gives no result; opcode 1 samples at
// signed Q15.16 coordinates coord_x, coord_y and gives one noise_value.
// Output channel (out_valid / out_stall): one transfer per sample, in order.
// A transfer completes on a rising edge with valid high and stall low.
// APB port: grid_scale at 0x0, wrap_edges at 0x4; write only while idle.
// Throughput: one item per cycle while out_stall stays low. The coordinate
// map is registered at the transfer edge, then cell multiply and lattice
// address, lattice read, y interpolation and x interpolation are each
// registered in turn.
// The lattice is four identical 256x16 RAM copies, one per corner, so all
// four corners are read together; writes go to all copies at the read
// stage, keeping samples ordered after earlier writes.
// Reset clears the pipeline valid bits and the registers (grid_scale 2,
// wrap_edges 0); lattice contents are undefined until written.
// When the receiver stalls, the result holds and bubbles in the pipeline
// still fill; in_stall rises only once every stage holds an item.
module bilinear_value_noise_sampler_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic [3:0]                   grid_col,
  input  logic [3:0]                   grid_row,
  input  logic [15:0]                  grid_value,
  input  logic signed [31:0]           coord_x,
  input  logic signed [31:0]           coord_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  noise_value,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bvns_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bvns_pkg::*;

  // config
  logic [3:0] grid_scale;
  logic       wrap_edges;
  logic [3:0] scale_eff;

  assign pready    = 1'b1;
  assign scale_eff = (grid_scale == 4'd0) ? 4'd1 : grid_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale <= SCALE_RESET;
      wrap_edges <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SCALE: grid_scale <= pwdata[3:0];
        REG_WRAP:  wrap_edges <= pwdata[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SCALE: prdata = {28'd0, grid_scale};
      REG_WRAP:  prdata = {31'd0, wrap_edges};
      default:   prdata = 32'd0;
    endcase
  end

  // pipeline registers
  logic                  v1, v2, v3, v4;
  logic                  ready1, ready2, ready3, ready4, ready5;

  logic                  op1;
  logic [IDX_W-1:0]      col1, row1;
  logic [VALUE_BITS-1:0] val1;
  logic [15:0]           ux1, uy1;

  logic                  op2;
  logic [ADDR_W-1:0]     waddr2;
  logic [VALUE_BITS-1:0] wdata2;
  logic [ADDR_W-1:0]     addr2 [CORNERS];
  logic [15:0]           wx2, wy2;

  logic [15:0]           wx3, wy3;
  logic [VALUE_BITS-1:0] rd3 [CORNERS];

  logic [VALUE_BITS-1:0] t1_4, t2_4;
  logic [15:0]           wx4;

  assign ready5   = !out_valid || !out_stall;
  assign ready4   = !v4 || ready5;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // stage 1: capture, map coordinates to 0..1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      op1  <= opcode;
      col1 <= grid_col[IDX_W-1:0];
      row1 <= grid_row[IDX_W-1:0];
      val1 <= grid_value[VALUE_BITS-1:0];
      ux1  <= unit_coord(coord_x);
      uy1  <= unit_coord(coord_y);
    end
  end

  // stage 2: scale, split cell / weight, corner addresses
  logic [19:0]      px, py;
  logic [IDX_W-1:0] x0, x1, y0, y1;

  function automatic logic [IDX_W-1:0] fix_index(input logic [4:0] idx,
                                                 input logic [3:0] scale,
                                                 input logic       wrap);
    logic [4:0] r;
    r = (wrap && idx == {1'b0, scale}) ? 5'd0 : idx;
    return (r >= 5'(GRID_SIDE)) ? IDX_W'(GRID_SIDE - 1) : r[IDX_W-1:0];
  endfunction

  function automatic logic [4:0] upper(input logic [3:0] c, input logic [3:0] scale);
    logic [4:0] n;
    n = {1'b0, c} + 5'd1;
    return (n > {1'b0, scale}) ? {1'b0, scale} : n;
  endfunction

  always_comb begin
    px = ux1 * scale_eff;
    py = uy1 * scale_eff;
    x0 = fix_index({1'b0, px[19:16]}, scale_eff, wrap_edges);
    y0 = fix_index({1'b0, py[19:16]}, scale_eff, wrap_edges);
    x1 = fix_index(upper(px[19:16], scale_eff), scale_eff, wrap_edges);
    y1 = fix_index(upper(py[19:16], scale_eff), scale_eff, wrap_edges);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      op2      <= op1;
      waddr2   <= {row1, col1};
      wdata2   <= val1;
      addr2[0] <= {y0, x0};
      addr2[1] <= {y1, x0};
      addr2[2] <= {y0, x1};
      addr2[3] <= {y1, x1};
      wx2      <= px[15:0];
      wy2      <= py[15:0];
    end
  end

  // stage 3: lattice read; writes land here too so order is kept
  logic ram_we;

  assign ram_we = v2 && (op2 == OP_WRITE) && ready3;

  for (genvar k = 0; k < CORNERS; k++) begin : g_corner
    bvns_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(GRID_SIDE * GRID_SIDE)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we),
      .waddr(waddr2),
      .wdata(wdata2),
      .re   (ready3),
      .raddr(addr2[k]),
      .rdata(rd3[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2 && (op2 == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      wx3 <= wx2;
      wy3 <= wy2;
    end
  end

  // stage 4: interpolate along y
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && v3) begin
      t1_4 <= lerp(rd3[0], rd3[1], wy3);
      t2_4 <= lerp(rd3[2], rd3[3], wy3);
      wx4  <= wx3;
    end
  end

  // stage 5: interpolate along x, output register
  logic [VALUE_BITS-1:0] res4;

  assign res4 = lerp(t1_4, t2_4, wx4);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && v4) begin
      noise_value <= 16'(res4);
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v1 && v2 && v3 && v4 && out_valid))
    else $error("input stalled with a free stage");

  a_upper_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (v2 && op2 == OP_SAMPLE) |-> ({1'b0, addr2[3][IDX_W-1:0]} <= {1'b0, scale_eff}))
    else $error("upper corner column beyond scale");

  a_held_weight: assert property (@(posedge clk) disable iff (rst)
    (v3 && !ready4) |=> (v3 && $stable(wx3) && $stable(wy3)))
    else $error("read stage lost its item while held");

  a_clean_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !v1 && !v4))
    else $error("valid bit set right after reset");
`endif

endmodule
